### rtl/srd_pkg.sv
// Shared types and constants for the sync port record deframer.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package srd_pkg;

   // Header pattern: HDR_A, HDR_B, HDR_A
   localparam logic [7:0] HDR_A = 8'd255;
   localparam logic [7:0] HDR_B = 8'd130;

   // Value bytes per record (1 to 15); only the first four reach the value
   localparam int VALUE_BYTES = 4;
   localparam int POS_W       = 4;

   localparam int BYTE_W   = 8;
   localparam int PORT_W   = 8;
   localparam int VALUE_W  = 32;
   localparam int MASK_W   = 64;
   localparam int MASK_CNT = 4;
   localparam int CSR_IDX_W = 8;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PORT_MASK_0 = 8'd0,
      CSR_PORT_MASK_1 = 8'd1,
      CSR_PORT_MASK_2 = 8'd2,
      CSR_PORT_MASK_3 = 8'd3
   } csr_index_type;

   // A record finished by the current word, before the port filter
   typedef struct packed {
      logic               done;
      logic [PORT_W-1:0]  port;
      logic [VALUE_W-1:0] value;
   } rec_type;

endpackage

### rtl/srd_if.sv
// Valid/ready channel interfaces for the deframer's input and result words.
// Depends on srd_pkg for field widths.
`timescale 1ns / 1ps

interface srd_req_if;
   logic                       valid;
   logic                       ready;
   logic [srd_pkg::BYTE_W-1:0] rx_byte;
   logic                       chunk_end;

   modport source (output valid, output rx_byte, output chunk_end, input ready);
   modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface srd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [srd_pkg::PORT_W-1:0]  port_id;
   logic [srd_pkg::VALUE_W-1:0] port_value;

   modport source (output valid, output port_id, output port_value, input ready);
   modport sink   (input valid, input port_id, input port_value, output ready);
endinterface

### rtl/sync_port_record_deframer_unit.sv
// Top level of the sync port record deframer: channel handshakes, result register.
// Depends on srd_pkg, srd_if, srd_frame and srd_mask.
`timescale 1ns / 1ps

// Takes one received word per cycle on req_chan and returns (port, value) records on
// rsp_chan. Each word is processed in the cycle it is accepted; a finished record whose
// port is set in the mask appears on rsp_chan the next cycle. Throughput is one word per
// clock: req_chan.ready is high whenever the result register is empty or is being taken
// in the same cycle, so a consumer that always takes results never stalls the input.
// The four 64-bit port masks are written through csr_we/csr_index/csr_wdata; indexes
// above 3 are ignored. Write them only while no word is in flight.

module sync_port_record_deframer_unit (
   input  logic                          clock,
   input  logic                          reset,
   srd_req_if.sink                       req_chan,
   srd_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [srd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srd_pkg::MASK_W-1:0]    csr_wdata
);
   import srd_pkg::*;

   rec_type            rec;
   logic               hit;
   logic               accept;
   logic               emit;

   logic               rsp_valid_ff;
   logic [PORT_W-1:0]  rsp_port_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign emit           = rec.done && hit;

   srd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_chan.rx_byte),
      .chunk_end (req_chan.chunk_end),
      .rec       (rec)
   );

   srd_mask u_mask (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .port      (rec.port),
      .hit       (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_port_ff  <= rec.port;
         rsp_value_ff <= rec.value;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.port_id    = rsp_port_ff;
   assign rsp_chan.port_value = rsp_value_ff;

   a_emit_needs_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result raised without an accepted word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !accept)
      else $error("word accepted while result stalled");

   a_masked_only: assert property (@(posedge clock) disable iff (reset)
      emit |-> rec.done)
      else $error("result without finished record");

endmodule

### rtl/srd_mask.sv
// Port registration mask registers, written through the CSR port,
// and the per-port lookup. Depends on srd_pkg.
`timescale 1ns / 1ps

module srd_mask (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [srd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srd_pkg::MASK_W-1:0]    csr_wdata,
   input  logic [srd_pkg::PORT_W-1:0]    port,
   output logic                          hit
);
   import srd_pkg::*;

   logic [MASK_W-1:0] mask_ff [MASK_CNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_CNT; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PORT_MASK_0: mask_ff[0] <= csr_wdata;
            CSR_PORT_MASK_1: mask_ff[1] <= csr_wdata;
            CSR_PORT_MASK_2: mask_ff[2] <= csr_wdata;
            CSR_PORT_MASK_3: mask_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // upper two bits pick the register, lower six the bit
   assign hit = mask_ff[port[7:6]][port[5:0]];

endmodule

### rtl/srd_frame.sv
// Header search and record assembly, one received word per accepted cycle.
// Depends on srd_pkg; reports each finished record before port filtering.
`timescale 1ns / 1ps

module srd_frame (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [srd_pkg::BYTE_W-1:0] rx_byte,
   input  logic                       chunk_end,
   output srd_pkg::rec_type           rec
);
   import srd_pkg::*;

   logic               hdr_ff, hdr_in;
   logic [BYTE_W-1:0]  old_ff, old_in;
   logic [BYTE_W-1:0]  new_ff, new_in;
   logic [1:0]         fill_ff, fill_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;

   logic [POS_W-1:0]   k;
   logic [VALUE_W-1:0] acc_merge;
   logic               done;

   always_comb begin
      hdr_in  = hdr_ff;
      old_in  = old_ff;
      new_in  = new_ff;
      fill_in = fill_ff;
      pos_in  = pos_ff;
      port_in = port_ff;
      acc_in  = acc_ff;
      done    = 1'b0;
      k       = pos_ff - POS_W'(1);
      acc_merge = acc_ff;
      // bytes past the fourth are consumed without touching the value
      if (k[POS_W-1:2] == '0) begin
         acc_merge = acc_ff | (VALUE_W'(rx_byte) << {k[1:0], 3'b000});
      end

      if (!hdr_ff) begin
         if (fill_ff == 2'd2 && old_ff == HDR_A && new_ff == HDR_B && rx_byte == HDR_A) begin
            hdr_in = 1'b1;
            pos_in = '0;
            acc_in = '0;
         end
         old_in = new_ff;
         new_in = rx_byte;
         if (fill_ff != 2'd2) begin
            fill_in = fill_ff + 2'd1;
         end
      end else if (pos_ff == '0) begin
         port_in = rx_byte;
         acc_in  = '0;
         pos_in  = POS_W'(1);
      end else if (pos_ff >= POS_W'(VALUE_BYTES)) begin
         done   = 1'b1;
         pos_in = '0;
         acc_in = '0;
      end else begin
         acc_in = acc_merge;
         pos_in = pos_ff + POS_W'(1);
      end

      if (chunk_end) begin
         hdr_in  = 1'b0;
         old_in  = '0;
         new_in  = '0;
         fill_in = '0;
         pos_in  = '0;
         port_in = '0;
         acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff  <= 1'b0;
         old_ff  <= '0;
         new_ff  <= '0;
         fill_ff <= '0;
         pos_ff  <= '0;
         port_ff <= '0;
         acc_ff  <= '0;
      end else if (accept) begin
         hdr_ff  <= hdr_in;
         old_ff  <= old_in;
         new_ff  <= new_in;
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
         port_ff <= port_in;
         acc_ff  <= acc_in;
      end
   end

   assign rec.done  = accept && done;
   assign rec.port  = port_ff;
   assign rec.value = acc_merge;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(VALUE_BYTES))
      else $error("record position past value length");

   a_no_rec_before_hdr: assert property (@(posedge clock) disable iff (reset)
      !hdr_ff |-> (pos_ff == '0 && acc_ff == '0))
      else $error("record progress without header");

   a_chunk_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && chunk_end) |=> (!hdr_ff && fill_ff == '0 && pos_ff == '0))
      else $error("state not cleared at chunk end");

   a_fill_sat: assert property (@(posedge clock) disable iff (reset)
      hdr_ff |-> fill_ff == 2'd2)
      else $error("header found before window filled");

endmodule
